FILE: sv/ffrv_pkg.sv
// Package: frame geometry, codes and beat types shared by the frame validator.
`default_nettype none
package ffrv_pkg;

  localparam int FRAME_LEN   = 36;
  localparam int PAYLOAD_LEN = 32;
  localparam int DATA_POS    = 3;
  localparam int SUM_POS     = 34;
  localparam int SUM_START   = 1;
  localparam int SUM_SPAN    = 33;

  localparam int POS_W     = 6;
  localparam int RAM_AW    = POS_W + 1;
  localparam int RAM_DEPTH = 1 << RAM_AW;
  localparam int PROT_LEN  = 10;

  localparam int VERSION_OFS = 0;
  localparam int SEQ_OFS     = 1;
  localparam int POINT_OFS   = 2;
  localparam int RECOV_OFS   = 6;

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CMD    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TAIL   = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_SUM    = POS_W'(SUM_POS);
  localparam logic [POS_W-1:0] POS_DATA   = POS_W'(DATA_POS);
  localparam logic [POS_W-1:0] IDX_LAST   = POS_W'(PAYLOAD_LEN - 1);
  localparam logic [POS_W:0]   SUM_LO     = (POS_W + 1)'(SUM_START);
  localparam logic [POS_W:0]   SUM_HI     = (POS_W + 1)'(SUM_START + SUM_SPAN);
  localparam logic [7:0]       LEN_BYTE   = 8'(PAYLOAD_LEN);

  localparam logic [1:0] KIND_REJECT  = 2'd0;
  localparam logic [1:0] KIND_DETAIL  = 2'd1;
  localparam logic [1:0] KIND_PROTECT = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HEADER = 3'd1;
  localparam logic [2:0] ST_CMD    = 3'd2;
  localparam logic [2:0] ST_LEN    = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_SUM    = 3'd5;

  localparam logic [7:0] CFG_HEADER  = 8'd0;
  localparam logic [7:0] CFG_TAIL    = 8'd1;
  localparam logic [7:0] CFG_DETAIL  = 8'd2;
  localparam logic [7:0] CFG_PROTECT = 8'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic [7:0]  version;
    logic [7:0]  sequence_res;
    logic [31:0] uvp_point_bits;
    logic [31:0] uvp_recovery_bits;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  version;
    logic [7:0]  sequence_res;
    logic [31:0] uvp_point_bits;
    logic [31:0] uvp_recovery_bits;
    logic        bank;
  } job_t;

endpackage
`default_nettype wire

FILE: sv/ffrv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffrv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/ffrv_front.sv
// Front end: byte intake, frame store writes, running checks and job issue.
`default_nettype none
module ffrv_front import ffrv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               in_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              retire,
  output logic                   push,
  output job_t                   push_job,
  output logic                   ram_we,
  output logic [RAM_AW-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata
);

  logic [7:0] header_byte;
  logic [7:0] tail_byte;
  logic [7:0] detail_code;
  logic [7:0] protect_code;

  logic [POS_W-1:0] byte_count;
  logic [7:0]       running_xor;
  logic             bank;
  logic [1:0]       pending;
  logic [1:0]       pending_next;

  logic [7:0] hdr_seen, cmd_seen, len_seen, tail_seen, sum_seen;
  logic [7:0] hdr_next, cmd_next, len_next, tail_next, sum_next;
  logic [7:0] prot_seen [PROT_LEN];
  logic [7:0] prot_next [PROT_LEN];

  logic             accept;
  logic [7:0]       b;
  logic [POS_W-1:0] pos;
  logic [7:0]       xor_base;
  logic [7:0]       xor_next;
  logic             in_span;
  logic             complete;
  logic [2:0]       status;

  assign cfg_ready = 1'b1;
  assign busy      = (pending == 2'd2);
  assign accept    = start & ~busy;
  assign b         = in_item.byte_value;
  assign pos       = in_item.frame_start ? '0 : byte_count;
  assign xor_base  = in_item.frame_start ? 8'd0 : running_xor;
  assign in_span   = ({1'b0, pos} >= SUM_LO) && ({1'b0, pos} < SUM_HI);
  assign xor_next  = in_span ? (xor_base ^ b) : xor_base;
  assign complete  = accept && (pos == POS_TAIL);

  assign hdr_next  = (pos == POS_HEADER) ? b : hdr_seen;
  assign cmd_next  = (pos == POS_CMD)    ? b : cmd_seen;
  assign len_next  = (pos == POS_LEN)    ? b : len_seen;
  assign tail_next = (pos == POS_TAIL)   ? b : tail_seen;
  assign sum_next  = (pos == POS_SUM)    ? b : sum_seen;

  for (genvar k = 0; k < PROT_LEN; k++) begin : g_prot
    assign prot_next[k] = (pos == POS_W'(DATA_POS + k)) ? b : prot_seen[k];
  end

  always_comb begin
    if (hdr_next != header_byte) begin
      status = ST_HEADER;
    end else if (cmd_next != detail_code && cmd_next != protect_code) begin
      status = ST_CMD;
    end else if (len_next != LEN_BYTE) begin
      status = ST_LEN;
    end else if (tail_next != tail_byte) begin
      status = ST_TAIL;
    end else if (sum_next != xor_next) begin
      status = ST_SUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    push_job        = '0;
    push_job.status = status;
    push_job.bank   = bank;
    if (status != ST_OK) begin
      push_job.kind = KIND_REJECT;
    end else if (cmd_next == detail_code) begin
      push_job.kind = KIND_DETAIL;
    end else begin
      push_job.kind              = KIND_PROTECT;
      push_job.version           = prot_next[VERSION_OFS];
      push_job.sequence_res      = prot_next[SEQ_OFS];
      push_job.uvp_point_bits    = {prot_next[POINT_OFS + 3], prot_next[POINT_OFS + 2],
                                    prot_next[POINT_OFS + 1], prot_next[POINT_OFS]};
      push_job.uvp_recovery_bits = {prot_next[RECOV_OFS + 3], prot_next[RECOV_OFS + 2],
                                    prot_next[RECOV_OFS + 1], prot_next[RECOV_OFS]};
    end
  end

  assign push      = complete;
  assign ram_we    = accept;
  assign ram_waddr = {bank, pos};
  assign ram_wdata = b;

  always_comb begin
    pending_next = pending;
    if (push && !retire) begin
      pending_next = pending + 2'd1;
    end else if (!push && retire) begin
      pending_next = pending - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= '0;
      tail_byte    <= '0;
      detail_code  <= '0;
      protect_code <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
      bank         <= 1'b0;
      pending      <= '0;
    end else begin
      pending <= pending_next;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HEADER:  header_byte  <= cfg_data;
          CFG_TAIL:    tail_byte    <= cfg_data;
          CFG_DETAIL:  detail_code  <= cfg_data;
          CFG_PROTECT: protect_code <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        byte_count  <= complete ? '0 : pos + POS_W'(1);
        running_xor <= complete ? 8'd0 : xor_next;
      end
      if (complete) begin
        bank <= ~bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_seen  <= hdr_next;
      cmd_seen  <= cmd_next;
      len_seen  <= len_next;
      tail_seen <= tail_next;
      sum_seen  <= sum_next;
      for (int k = 0; k < PROT_LEN; k++) begin
        prot_seen[k] <= prot_next[k];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/ffrv_queue.sv
// Two-entry job queue between the front end and the result sequencer.
`default_nettype none
module ffrv_queue import ffrv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign empty = (fill == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (!push && pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ffrv_back.sv
// Back end: turns queued jobs into result beats, reading payload from the store.
`default_nettype none
module ffrv_back import ffrv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire job_t              q_head,
  output logic                   q_pop,
  output logic                   retire,
  output logic [RAM_AW-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  output logic                   strobe,
  output res_t                   result
);

  logic             active;
  job_t             job;
  logic [POS_W-1:0] idx;
  logic             idx_last;
  logic             is_detail;
  logic             p_valid;
  logic [POS_W-1:0] p_idx;
  logic             p_last;
  logic             emit_job;
  res_t             result_next;

  assign is_detail = (job.kind == KIND_DETAIL);
  assign idx_last  = (idx == IDX_LAST);
  assign q_pop     = ~active & ~q_empty;
  assign retire    = active & (~is_detail | idx_last);
  assign emit_job  = active & ~is_detail;
  assign ram_raddr = {job.bank, POS_DATA + idx};

  always_comb begin
    result_next = '0;
    if (p_valid) begin
      result_next.kind          = KIND_DETAIL;
      result_next.status        = ST_OK;
      result_next.payload_byte  = ram_rdata;
      result_next.payload_index = p_idx;
      result_next.last          = p_last;
    end else begin
      result_next.kind              = job.kind;
      result_next.status            = job.status;
      result_next.version           = job.version;
      result_next.sequence_res      = job.sequence_res;
      result_next.uvp_point_bits    = job.uvp_point_bits;
      result_next.uvp_recovery_bits = job.uvp_recovery_bits;
      result_next.last              = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      p_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      p_valid <= active & is_detail;
      strobe  <= p_valid | emit_job;
      if (active) begin
        if (!is_detail || idx_last) begin
          active <= 1'b0;
        end
      end else if (!q_empty) begin
        active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
      idx <= '0;
    end else if (active) begin
      idx <= idx + POS_W'(1);
    end
    p_idx  <= idx;
    p_last <= idx_last;
    if (p_valid || emit_job) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/fixed_frame_receive_validator_unit.sv
// Top level of the fixed-length frame receive validator.
//
//   Channel   Handshake              Beat
//   in        start / busy           in_item: one received frame byte
//   result    strobe (no back-press) result: one result beat per strobe
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while busy is low. A rejected or protect frame gives its
// single beat once its job has passed the queue, the job register and the result register;
// a detail frame's first payload beat also passes the registered store read, then one beat
// per cycle follows from the two-bank store. A queued frame waits for the one ahead of it.
// Busy rises only while two completed frames still hold both store banks, and falls in the
// cycle after the older job retires: at its last store read, or when taken up if not detail.
// Reset is synchronous and clears byte counting, checks and queued jobs.
`default_nettype none
module fixed_frame_receive_validator_unit import ffrv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_item,
  output logic            strobe,
  output res_t            result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic              retire;
  logic              push;
  job_t              push_job;
  logic              q_pop;
  logic              q_empty;
  job_t              q_head;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  ffrv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .retire    (retire),
    .push      (push),
    .push_job  (push_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  ffrv_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffrv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  ffrv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .retire    (retire),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
`default_nettype wire
